>>> rtl/vrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

	// ray parameter t: unsigned Q2.30
	localparam int T_FRAC = 30;
	localparam int T_W    = 32;
	localparam logic [T_W-1:0] T_ONE = 32'h4000_0000;
	localparam logic [T_W-1:0] T_MAX = 32'h8000_0000;

	// direction magnitude split for the advance multiply
	localparam int ADV_SPLIT = 15;

	// configuration registers
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int LIMIT_W     = 16;
	localparam int RADIUS_W    = 12;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LIMIT  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_RADIUS = 1'b1;
	localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd1000;
	localparam logic [RADIUS_W-1:0]    RADIUS_RESET    = 12'd10;

	localparam logic FUNC_START = 1'b0;

	localparam int REASON_W = 3;
	typedef enum logic [REASON_W-1:0] {
		REASON_QUERY   = 3'd0,
		REASON_BLOCKED = 3'd1,
		REASON_NEAR    = 3'd2,
		REASON_LIMIT   = 3'd3,
		REASON_SEG_END = 3'd4
	} vrt_reason_t;

	// item class decided by the front end
	localparam int KIND_W = 2;
	typedef enum logic [KIND_W-1:0] {
		KIND_START,
		KIND_CLEAR,
		KIND_BLOCKED
	} vrt_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_SETUP,
		ST_DIV_ITER,
		ST_SELECT,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADVANCE,
		ST_MOVE,
		ST_CHECK,
		ST_NEAR_SQ,
		ST_NEAR_CMP,
		ST_EMIT
	} vrt_state_t;

endpackage

`default_nettype wire

>>> rtl/vrt_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// input item channel
interface vrt_in_if #(parameter int COORD_W = 28) ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic signed [COORD_W-1:0] start_x;
	logic signed [COORD_W-1:0] start_y;
	logic signed [COORD_W-1:0] start_z;
	logic signed [COORD_W-1:0] target_x;
	logic signed [COORD_W-1:0] target_y;
	logic signed [COORD_W-1:0] target_z;
	logic                      occupied;

	modport source (output valid, func, start_x, start_y, start_z,
		target_x, target_y, target_z, occupied, input ready);
	modport sink (input valid, func, start_x, start_y, start_z,
		target_x, target_y, target_z, occupied, output ready);
endinterface

// result channel
interface vrt_out_if #(parameter int CELL_W = 12) ();
	logic                     valid;
	logic                     ready;
	logic signed [CELL_W-1:0] voxel_x;
	logic signed [CELL_W-1:0] voxel_y;
	logic signed [CELL_W-1:0] voxel_z;
	logic                     done_res;
	logic [2:0]               end_reason;

	modport source (output valid, voxel_x, voxel_y, voxel_z, done_res, end_reason,
		input ready);
	modport sink (input valid, voxel_x, voxel_y, voxel_z, done_res, end_reason,
		output ready);
endinterface

// configuration write channel
interface vrt_cfg_if ();
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/voxel_ray_traversal_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// A start item gives its first query after the range check and near-target squares; a clear
// reply gives the next result after up to three divisions on one shared divider, the
// advance multiply, then the near-target squares.
// Items are worked one at a time; a two-entry queue and the result register let input
// and output stall on their own. Reset idles the walk and loads step_limit 1000 and
// near_radius 10; there is no clearing pass.

module voxel_ray_traversal_3d #(
	parameter int COORD_INT_BITS  = 12,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	vrt_in_if.sink    in_ch,
	vrt_out_if.source out_ch,
	vrt_cfg_if.sink   cfg_ch
);
	import vrt_pkg::*;

	localparam int W  = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int EW = KIND_W + 6 * W + 3 * (W + 1);

	logic          push;
	logic          push_ready;
	logic [EW-1:0] push_data;
	logic          q_valid;
	logic          q_pop;
	logic [EW-1:0] q_data;

	vrt_front #(
		.COORD_INT_BITS (COORD_INT_BITS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.in_ch     (in_ch),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready)
	);

	vrt_queue #(
		.WIDTH(EW),
		.DEPTH(2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.push_ready(push_ready),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	vrt_back #(
		.COORD_INT_BITS (COORD_INT_BITS),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_data (q_data),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

endmodule

`default_nettype wire

>>> rtl/vrt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vrt_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = PTR_W + 1;

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> rtl/vrt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vrt_front #(
	parameter int COORD_INT_BITS  = 12,
	parameter int COORD_FRAC_BITS = 16,
	localparam int W  = COORD_INT_BITS + COORD_FRAC_BITS,
	localparam int EW = vrt_pkg::KIND_W + 6 * W + 3 * (W + 1)
) (
	vrt_in_if.sink        in_ch,
	output logic          push,
	output logic [EW-1:0] push_data,
	input  logic          push_ready
);
	import vrt_pkg::*;

	localparam int DIRW = W + 1;

	vrt_kind_t       kind;
	logic [DIRW-1:0] dir_x;
	logic [DIRW-1:0] dir_y;
	logic [DIRW-1:0] dir_z;

	assign in_ch.ready = push_ready;
	assign push        = in_ch.valid;

	// classify the item
	always_comb begin
		if (in_ch.func == FUNC_START) begin
			kind = KIND_START;
		end else if (in_ch.occupied) begin
			kind = KIND_BLOCKED;
		end else begin
			kind = KIND_CLEAR;
		end
	end

	// direction = target - start, one bit wider
	assign dir_x = {in_ch.target_x[W-1], in_ch.target_x} - {in_ch.start_x[W-1], in_ch.start_x};
	assign dir_y = {in_ch.target_y[W-1], in_ch.target_y} - {in_ch.start_y[W-1], in_ch.start_y};
	assign dir_z = {in_ch.target_z[W-1], in_ch.target_z} - {in_ch.start_z[W-1], in_ch.start_z};

	assign push_data = {kind, dir_z, dir_y, dir_x,
		in_ch.target_z, in_ch.target_y, in_ch.target_x,
		in_ch.start_z, in_ch.start_y, in_ch.start_x};

endmodule

`default_nettype wire

>>> rtl/vrt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vrt_back #(
	parameter int COORD_INT_BITS  = 12,
	parameter int COORD_FRAC_BITS = 16,
	localparam int W  = COORD_INT_BITS + COORD_FRAC_BITS,
	localparam int EW = vrt_pkg::KIND_W + 6 * W + 3 * (W + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  logic [EW-1:0] q_data,
	vrt_out_if.source     out_ch,
	vrt_cfg_if.sink       cfg_ch
);
	import vrt_pkg::*;

	localparam int I     = COORD_INT_BITS;
	localparam int F     = COORD_FRAC_BITS;
	localparam int DIRW  = W + 1;
	localparam int PW    = W + 4;
	localparam int DW    = PW + 1;
	localparam int CW    = DW + 1;
	localparam int HIW   = DIRW - ADV_SPLIT;
	localparam int OPW   = (HIW > ADV_SPLIT) ? HIW : ADV_SPLIT;
	localparam int PRW   = OPW + T_W;
	localparam int SUMW  = PRW + ADV_SPLIT + 1;
	localparam int NRW   = RADIUS_W + F;
	localparam int SQW   = 2 * NRW;
	localparam int ACCW  = SQW + 2;
	localparam int CMPW  = (W + 1 > NRW) ? W + 1 : NRW;
	localparam int QW    = T_FRAC + 1;
	localparam int DIV_STEPS = T_FRAC / 2;
	localparam int DCW   = $clog2(DIV_STEPS);

	vrt_state_t state_q, state_d;
	logic       out_load;

	// walk state
	logic signed [DIRW-1:0] dir_q   [3];
	logic signed [PW-1:0]   point_q [3];
	logic signed [I-1:0]    cell_q  [3];
	logic signed [W-1:0]    end_q   [3];
	logic [T_W-1:0]         travelled_q;
	logic [LIMIT_W-1:0]     steps_q;
	logic                   walking_q;
	logic [LIMIT_W-1:0]     limit_q;
	logic [RADIUS_W-1:0]    radius_q;

	// sequencing and arithmetic registers
	logic [1:0]      axis_q;
	logic [DIRW-1:0] div_r_q;
	logic [DIRW-1:0] div_den_q;
	logic [QW-1:0]   div_quo_q;
	logic [DCW-1:0]  div_cnt_q;
	logic [T_W-1:0]  t_q [3];
	logic [T_W-1:0]  t_sel_q;
	logic [1:0]      sel_axis_q;
	logic [PRW-1:0]  p_lo_q;
	logic [PRW-1:0]  p_hi_q;
	logic [NRW-1:0]  d_q [3];
	logic [SQW-1:0]  sq_q;
	logic [ACCW-1:0] acc_q;
	vrt_reason_t     emit_reason_q;

	// result register
	logic             out_valid_q;
	logic [I-1:0]     vox_q [3];
	vrt_reason_t      reason_q;

	// queue entry fields
	vrt_kind_t           e_kind;
	logic signed [W-1:0] e_start [3];
	logic signed [W-1:0] e_end   [3];
	logic [DIRW-1:0]     e_dir   [3];

	always_comb begin
		e_kind = vrt_kind_t'(q_data[EW-1 -: KIND_W]);
		for (int k = 0; k < 3; k++) begin
			e_start[k] = q_data[k * W +: W];
			e_end[k]   = q_data[(3 + k) * W +: W];
			e_dir[k]   = q_data[6 * W + k * DIRW +: DIRW];
		end
	end

	// current axis operands
	logic signed [DIRW-1:0] dir_cur;
	logic signed [PW-1:0]   point_cur;
	logic [I-1:0]           cell_cur;
	logic                   dir_zero;
	logic                   dir_pos;
	logic [DIRW-1:0]        den_cur;

	assign dir_cur   = dir_q[axis_q];
	assign point_cur = point_q[axis_q];
	assign cell_cur  = cell_q[axis_q];
	assign dir_zero  = (dir_cur == '0);
	assign dir_pos   = !dir_cur[DIRW-1] && !dir_zero;
	assign den_cur   = dir_cur[DIRW-1] ? (~dir_cur + 1'b1) : dir_cur;

	// distance to exit face and first quotient bit
	logic [I:0]    face;
	logic [DW-1:0] face_fx;
	logic [DW-1:0] diff;
	logic [DW-1:0] face_dist;
	logic          ge1;
	logic          ge2;
	logic [DIRW-1:0] r0;

	assign face      = {cell_cur[I-1], cell_cur} + {{I{1'b0}}, dir_pos};
	assign face_fx   = {{(DW - I - 1 - F){face[I]}}, face, {F{1'b0}}};
	assign diff      = face_fx - {point_cur[PW-1], point_cur};
	assign face_dist = diff[DW-1] ? (~diff + 1'b1) : diff;
	assign ge1       = CW'(face_dist) >= CW'(den_cur);
	assign ge2       = CW'(face_dist) >= CW'({den_cur, 1'b0});
	assign r0        = ge1 ? DIRW'(face_dist - DW'(den_cur)) : DIRW'(face_dist);

	// two restoring division steps per cycle
	logic [DIRW:0] r1, r1s, r2, r2s;
	logic          b1, b2;

	always_comb begin
		r1  = {div_r_q, 1'b0};
		b1  = r1 >= {1'b0, div_den_q};
		r1s = b1 ? (r1 - {1'b0, div_den_q}) : r1;
		r2  = {r1s[DIRW-1:0], 1'b0};
		b2  = r2 >= {1'b0, div_den_q};
		r2s = b2 ? (r2 - {1'b0, div_den_q}) : r2;
	end

	// smallest time, x before y before z on a tie
	logic [T_W-1:0] t_min;
	logic [1:0]     axis_min;

	always_comb begin
		t_min    = t_q[0];
		axis_min = 2'd0;
		if (t_q[1] < t_min) begin
			t_min    = t_q[1];
			axis_min = 2'd1;
		end
		if (t_q[2] < t_min) begin
			t_min    = t_q[2];
			axis_min = 2'd2;
		end
	end

	// advance multiply: magnitude halves times t
	logic [OPW-1:0]  mul_op;
	logic [PRW-1:0]  mul_prod;
	logic [SUMW-1:0] adv_sum;
	logic [PW-1:0]   adv_mag;
	logic [PW-1:0]   adv_step;

	assign mul_op   = (state_q == ST_MUL_HI) ? OPW'(den_cur[DIRW-1:ADV_SPLIT])
		: OPW'(den_cur[ADV_SPLIT-1:0]);
	assign mul_prod = PRW'(mul_op) * PRW'(t_sel_q);
	assign adv_sum  = (SUMW'(p_hi_q) << ADV_SPLIT) + SUMW'(p_lo_q)
		+ (SUMW'(1) << (T_FRAC - 1));
	assign adv_mag  = adv_sum[T_FRAC +: PW];
	assign adv_step = dir_cur[DIRW-1] ? (~adv_mag + 1'b1) : adv_mag;

	// cell move and travelled sum
	logic [T_W-1:0] trav_sum;
	logic           trav_over;
	logic           sel_pos;

	assign trav_sum  = travelled_q + t_sel_q;
	assign trav_over = trav_sum > T_ONE;
	assign sel_pos   = !dir_q[sel_axis_q][DIRW-1] && (dir_q[sel_axis_q] != '0);

	// near test: per-axis corner distance and range check
	logic [NRW-1:0]  r_fx;
	logic [W:0]      nd [3];
	logic            far;
	logic            steps_over;

	assign r_fx       = {radius_q, {F{1'b0}}};
	assign steps_over = steps_q > limit_q;

	always_comb begin
		logic [W:0] cd;
		far = 1'b0;
		for (int k = 0; k < 3; k++) begin
			cd    = {cell_q[k][I-1], cell_q[k], {F{1'b0}}} - {end_q[k][W-1], end_q[k]};
			nd[k] = cd[W] ? (~cd + 1'b1) : cd;
			if (CMPW'(nd[k]) >= CMPW'(r_fx)) begin
				far = 1'b1;
			end
		end
	end

	// square of one distance, or of the radius last
	logic [NRW-1:0] sq_op;
	logic [SQW-1:0] sq_prod;

	always_comb begin
		unique case (axis_q)
			2'd0:    sq_op = d_q[0];
			2'd1:    sq_op = d_q[1];
			2'd2:    sq_op = d_q[2];
			default: sq_op = r_fx;
		endcase
	end
	assign sq_prod = SQW'(sq_op) * SQW'(sq_op);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (e_kind)
						KIND_START:   state_d = ST_CHECK;
						KIND_CLEAR:   state_d = walking_q ? ST_DIV_SETUP : ST_IDLE;
						KIND_BLOCKED: state_d = walking_q ? ST_EMIT : ST_IDLE;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIV_SETUP: begin
				if (dir_zero || ge2) begin
					state_d = (axis_q == 2'd2) ? ST_SELECT : ST_DIV_SETUP;
				end else begin
					state_d = ST_DIV_ITER;
				end
			end
			ST_DIV_ITER: begin
				if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
					state_d = (axis_q == 2'd2) ? ST_SELECT : ST_DIV_SETUP;
				end
			end
			ST_SELECT:   state_d = ST_MUL_LO;
			ST_MUL_LO:   state_d = ST_MUL_HI;
			ST_MUL_HI:   state_d = ST_ADVANCE;
			ST_ADVANCE:  state_d = (axis_q == 2'd2) ? ST_MOVE : ST_MUL_LO;
			ST_MOVE:     state_d = trav_over ? ST_EMIT : ST_CHECK;
			ST_CHECK:    state_d = (steps_over || far) ? ST_EMIT : ST_NEAR_SQ;
			ST_NEAR_SQ:  state_d = (axis_q == 2'd3) ? ST_NEAR_CMP : ST_NEAR_SQ;
			ST_NEAR_CMP: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: walk flag, result valid, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walking_q   <= 1'b0;
			out_valid_q <= 1'b0;
			limit_q     <= LIMIT_RESET;
			radius_q    <= RADIUS_RESET;
		end else begin
			if (q_pop && e_kind == KIND_START) begin
				walking_q <= 1'b1;
			end else if (out_load && emit_reason_q != REASON_QUERY) begin
				walking_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					CFG_STEP_LIMIT:  limit_q  <= cfg_ch.data[LIMIT_W-1:0];
					CFG_NEAR_RADIUS: radius_q <= cfg_ch.data[RADIUS_W-1:0];
					default:         limit_q  <= limit_q;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				axis_q <= 2'd0;
				if (q_valid) begin
					emit_reason_q <= REASON_BLOCKED;
					if (e_kind == KIND_START) begin
						for (int k = 0; k < 3; k++) begin
							dir_q[k]   <= e_dir[k];
							end_q[k]   <= e_end[k];
							point_q[k] <= {{(PW - W){e_start[k][W-1]}}, e_start[k]}
								+ (PW'(1) << (F - 1));
							cell_q[k]  <= e_start[k][W-1:F];
						end
						travelled_q <= '0;
						steps_q     <= '0;
					end
				end
			end
			ST_DIV_SETUP: begin
				div_den_q <= den_cur;
				div_r_q   <= r0;
				div_quo_q <= QW'(ge1);
				div_cnt_q <= '0;
				if (dir_zero || ge2) begin
					t_q[axis_q] <= T_MAX;
					axis_q      <= axis_q + 1'b1;
				end
			end
			ST_DIV_ITER: begin
				div_r_q   <= r2s[DIRW-1:0];
				div_quo_q <= {div_quo_q[QW-3:0], b1, b2};
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
					t_q[axis_q] <= {1'b0, div_quo_q[QW-3:0], b1, b2};
					axis_q      <= axis_q + 1'b1;
				end
			end
			ST_SELECT: begin
				t_sel_q    <= t_min;
				sel_axis_q <= axis_min;
				axis_q     <= 2'd0;
			end
			ST_MUL_LO: p_lo_q <= mul_prod;
			ST_MUL_HI: p_hi_q <= mul_prod;
			ST_ADVANCE: begin
				point_q[axis_q] <= point_cur + adv_step;
				axis_q          <= axis_q + 1'b1;
			end
			ST_MOVE: begin
				cell_q[sel_axis_q] <= cell_q[sel_axis_q] + (sel_pos ? I'(1) : '1);
				travelled_q        <= trav_sum;
				emit_reason_q      <= REASON_SEG_END;
			end
			ST_CHECK: begin
				axis_q <= 2'd0;
				acc_q  <= '0;
				for (int k = 0; k < 3; k++) begin
					d_q[k] <= NRW'(nd[k]);
				end
				if (steps_over) begin
					emit_reason_q <= REASON_LIMIT;
				end else begin
					emit_reason_q <= REASON_QUERY;
					if (steps_q != '1) begin
						steps_q <= steps_q + 1'b1;
					end
				end
			end
			ST_NEAR_SQ: begin
				sq_q <= sq_prod;
				if (axis_q != 2'd0) begin
					acc_q <= acc_q + ACCW'(sq_q);
				end
				axis_q <= axis_q + 1'b1;
			end
			ST_NEAR_CMP: begin
				emit_reason_q <= (acc_q < ACCW'(sq_q)) ? REASON_NEAR : REASON_QUERY;
			end
			ST_EMIT: begin
				if (out_load) begin
					for (int k = 0; k < 3; k++) begin
						vox_q[k] <= cell_q[k];
					end
					reason_q <= emit_reason_q;
				end
			end
			default: axis_q <= 2'd0;
		endcase
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.voxel_x    = vox_q[0];
	assign out_ch.voxel_y    = vox_q[1];
	assign out_ch.voxel_z    = vox_q[2];
	assign out_ch.done_res   = (reason_q != REASON_QUERY);
	assign out_ch.end_reason = reason_q;
	assign cfg_ch.ready      = 1'b1;

endmodule

`default_nettype wire
